### rtl/core/wrmsn_pkg.sv
// Shared widths, register indexes and reset values of the weighted RMS error norm.
package wrmsn_pkg;

  // Field widths.
  localparam int VALUE_W = 32;
  localparam int SCALE_W = 31;
  localparam int TOL_W   = 32;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int WIDE_W  = 64;

  // Vector length before the element position wraps.
  localparam int MAX_ELEMENTS = 1024;
  localparam logic [INDEX_W-1:0] POS_LAST = INDEX_W'(MAX_ELEMENTS - 1);

  // Saturation limit of the controlled-element count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REL_TOL = 2'd1;
  localparam logic [TOL_W-1:0] TOL_RESET = 32'd4295;

endpackage

### rtl/core/wrmsn_in_if.sv
// Input channel: one solution element per word.
interface wrmsn_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [wrmsn_pkg::VALUE_W-1:0] coarse_value;
  logic signed [wrmsn_pkg::VALUE_W-1:0] refined_value;
  logic signed [wrmsn_pkg::VALUE_W-1:0] prior_value;
  logic        [wrmsn_pkg::SCALE_W-1:0] element_scale;
  logic                               is_controlled;
  logic                               last_element;

  modport source (output valid, coarse_value, refined_value, prior_value, element_scale,
                  is_controlled, last_element, input ready);
  modport sink   (input valid, coarse_value, refined_value, prior_value, element_scale,
                  is_controlled, last_element, output ready);
endinterface

### rtl/core/wrmsn_out_if.sv
// Output channel: one norm result word per vector.
interface wrmsn_out_if;
  logic                          valid;
  logic                          ready;
  logic [wrmsn_pkg::VALUE_W-1:0] error_norm;
  logic [wrmsn_pkg::VALUE_W-1:0] largest_ratio;
  logic [wrmsn_pkg::INDEX_W-1:0] largest_index;
  logic                          any_controlled;

  modport source (output valid, error_norm, largest_ratio, largest_index, any_controlled,
                  input ready);
  modport sink   (input valid, error_norm, largest_ratio, largest_index, any_controlled,
                  output ready);
endinterface

### rtl/core/wrmsn_csub.sv
// Shared compare-and-subtract unit for the dividers and the square root.
module wrmsn_csub (
  input  logic [wrmsn_pkg::WIDE_W:0]   minuend_i,
  input  logic [wrmsn_pkg::WIDE_W-1:0] subtrahend_i,
  output logic                         ge_o,
  output logic [wrmsn_pkg::WIDE_W-1:0] diff_o
);

  logic [wrmsn_pkg::WIDE_W:0] diff_full;

  // One wide subtraction, and a separate comparison for the greater-or-equal flag.
  assign diff_full = minuend_i - {1'b0, subtrahend_i};
  assign ge_o      = minuend_i >= {1'b0, subtrahend_i};
  assign diff_o    = diff_full[wrmsn_pkg::WIDE_W-1:0];

endmodule

### rtl/core/weighted_rms_error_norm.sv
// Top level of the weighted RMS error norm: sequencer, multiplier and accumulators.
//
//   channel   direction  payload                                           handshake
//   in_i      sink       coarse/refined/prior value, scale, flags          valid/ready
//   out_o     source     error_norm, largest_ratio, largest_index, any     valid/ready
//   cfg       write      cfg_idx_i, cfg_wdata_i                            cfg_we_i
//
// A controlled element runs two scale products, an add, a setup step, 32 division steps on
// the shared compare-subtract unit, a square and the accumulate; a zero difference or a
// saturated ratio skips the division. An uncontrolled element skips all of this work.
// A last element adds the 64-step mean division and the 32-step square root, which are
// skipped without any controlled element. Reset clears the sequencer, the accumulators and the
// output valid and loads both tolerances; a waiting result stalls only the next final step.
module weighted_rms_error_norm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  wrmsn_in_if.sink                             in_i,
  wrmsn_out_if.source                          out_o,
  input  logic                                 cfg_we_i,
  input  logic [wrmsn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wrmsn_pkg::TOL_W-1:0]          cfg_wdata_i
);

  localparam int W  = wrmsn_pkg::WIDE_W;
  localparam int VW = wrmsn_pkg::VALUE_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL_A     = 4'd1;
  localparam logic [3:0] S_MUL_B     = 4'd2;
  localparam logic [3:0] S_ADD       = 4'd3;
  localparam logic [3:0] S_DIV_INIT  = 4'd4;
  localparam logic [3:0] S_DIV       = 4'd5;
  localparam logic [3:0] S_SQ        = 4'd6;
  localparam logic [3:0] S_ACC       = 4'd7;
  localparam logic [3:0] S_FIN       = 4'd8;
  localparam logic [3:0] S_MDIV      = 4'd9;
  localparam logic [3:0] S_ROOT_INIT = 4'd10;
  localparam logic [3:0] S_SQRT      = 4'd11;
  localparam logic [3:0] S_DONE      = 4'd12;

  logic [3:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  logic [wrmsn_pkg::TOL_W-1:0] abs_tol_q, abs_tol_d, rel_tol_q, rel_tol_d;

  // Latched element.
  logic [VW-1:0] coarse_q, coarse_d, refined_q, refined_d, prior_q, prior_d;
  logic [wrmsn_pkg::SCALE_W-1:0] scale_q, scale_d;
  logic last_q, last_d;

  // Datapath registers.
  logic [VW-1:0] mmax_q, mmax_d, dif_q, dif_d;
  logic [W-1:0]  prod_q, prod_d, scl_q, scl_d, rem_q, rem_d, dq_q, dq_d, root_q, root_d;

  // Vector accumulators.
  logic [W-1:0]                      sum_q, sum_d;
  logic [wrmsn_pkg::COUNT_W-1:0]     count_q, count_d;
  logic [wrmsn_pkg::INDEX_W-1:0]     pos_q, pos_d, best_pos_q, best_pos_d;
  logic [VW-1:0]                     best_q, best_d;
  logic                              seen_q, seen_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic [VW-1:0]                 norm_q, norm_d, oratio_q, oratio_d;
  logic [wrmsn_pkg::INDEX_W-1:0] oidx_q, oidx_d;
  logic                          oany_q, oany_d;

  // Shared units.
  logic [VW-1:0] mul_a, mul_b;
  logic [W-1:0]  mul_p;
  logic [W:0]    cs_t;
  logic [W-1:0]  cs_d, cs_diff, sqrt_bit;
  logic          cs_ge;

  // Magnitudes of the latched values.
  logic [VW-1:0] mag_c, mag_r, mag_p, mag_m1;
  logic [VW:0]   diff33, mag33;
  logic [W:0]    sum65;
  logic [VW-1:0] ratio;
  logic          in_fire, out_fire;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  assign out_o.valid          = out_valid_q;
  assign out_o.error_norm     = norm_q;
  assign out_o.largest_ratio  = oratio_q;
  assign out_o.largest_index  = oidx_q;
  assign out_o.any_controlled = oany_q;

  // Magnitude and maximum of the three values; the difference spans 33 bits.
  assign mag_c  = coarse_q[VW-1]  ? (~coarse_q + 1'b1)  : coarse_q;
  assign mag_r  = refined_q[VW-1] ? (~refined_q + 1'b1) : refined_q;
  assign mag_p  = prior_q[VW-1]   ? (~prior_q + 1'b1)   : prior_q;
  assign mag_m1 = (mag_c > mag_p) ? mag_c : mag_p;
  assign diff33 = {refined_q[VW-1], refined_q} - {coarse_q[VW-1], coarse_q};
  assign mag33  = diff33[VW] ? (~diff33 + 1'b1) : diff33;

  // The shared 32 by 32 multiplier.
  always_comb begin
    unique case (state_q)
      S_MUL_A: begin
        mul_a = abs_tol_q;
        mul_b = {1'b0, scale_q};
      end
      S_MUL_B: begin
        mul_a = rel_tol_q;
        mul_b = mmax_q;
      end
      default: begin
        mul_a = dq_q[VW-1:0];
        mul_b = dq_q[VW-1:0];
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Operand selection for the compare-subtract unit.
  assign sqrt_bit = W'(1) << {cnt_q[4:0], 1'b0};
  always_comb begin
    unique case (state_q)
      S_DIV_INIT: begin
        cs_t = {17'd0, dif_q, 16'd0};
        cs_d = scl_q;
      end
      S_SQRT: begin
        cs_t = {1'b0, rem_q};
        cs_d = root_q | sqrt_bit;
      end
      default: begin
        cs_t = {rem_q, dq_q[W-1]};
        cs_d = scl_q;
      end
    endcase
  end

  wrmsn_csub u_csub (
    .minuend_i    (cs_t),
    .subtrahend_i (cs_d),
    .ge_o         (cs_ge),
    .diff_o       (cs_diff)
  );

  assign ratio = dq_q[VW-1:0];
  assign sum65 = {1'b0, sum_q} + {1'b0, prod_q};

  // Sequencer and next-state logic.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    abs_tol_d   = abs_tol_q;
    rel_tol_d   = rel_tol_q;
    coarse_d    = coarse_q;
    refined_d   = refined_q;
    prior_d     = prior_q;
    scale_d     = scale_q;
    last_d      = last_q;
    mmax_d      = mmax_q;
    dif_d       = dif_q;
    prod_d      = prod_q;
    scl_d       = scl_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    root_d      = root_q;
    sum_d       = sum_q;
    count_d     = count_q;
    pos_d       = pos_q;
    best_d      = best_q;
    best_pos_d  = best_pos_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    norm_d      = norm_q;
    oratio_d    = oratio_q;
    oidx_d      = oidx_q;
    oany_d      = oany_q;

    // Tolerance writes; indexes beyond the list are dropped.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wrmsn_pkg::REG_ABS_TOL: abs_tol_d = cfg_wdata_i;
        wrmsn_pkg::REG_REL_TOL: rel_tol_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          coarse_d  = in_i.coarse_value;
          refined_d = in_i.refined_value;
          prior_d   = in_i.prior_value;
          scale_d   = in_i.element_scale;
          last_d    = in_i.last_element;
          if (in_i.is_controlled) begin
            state_d = S_MUL_A;
          end else if (in_i.last_element) begin
            state_d = S_FIN;
          end else begin
            pos_d = (pos_q == wrmsn_pkg::POS_LAST) ? '0 : pos_q + 1'b1;
          end
        end
      end
      S_MUL_A: begin
        prod_d  = mul_p;
        mmax_d  = (mag_r > mag_m1) ? mag_r : mag_m1;
        dif_d   = mag33[VW-1:0];
        state_d = S_MUL_B;
      end
      S_MUL_B: begin
        scl_d   = prod_q;
        prod_d  = mul_p;
        state_d = S_ADD;
      end
      S_ADD: begin
        scl_d   = scl_q + prod_q;
        state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        // Zero difference gives zero; a quotient that would not fit saturates.
        if (dif_q == '0) begin
          dq_d    = '0;
          state_d = S_SQ;
        end else if (cs_ge) begin
          dq_d    = {{(W-VW){1'b0}}, {VW{1'b1}}};
          state_d = S_SQ;
        end else begin
          rem_d   = cs_t[W-1:0];
          dq_d    = '0;
          cnt_d   = 6'd31;
          state_d = S_DIV;
        end
      end
      S_DIV, S_MDIV: begin
        // One restoring division step.
        rem_d = cs_ge ? cs_diff : cs_t[W-1:0];
        dq_d  = {dq_q[W-2:0], cs_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = (state_q == S_DIV) ? S_SQ : S_ROOT_INIT;
        end
      end
      S_SQ: begin
        prod_d  = mul_p;
        state_d = S_ACC;
      end
      S_ACC: begin
        sum_d = sum65[W] ? '1 : sum65[W-1:0];
        if (!seen_q || ratio > best_q) begin
          best_d     = ratio;
          best_pos_d = pos_q;
        end
        seen_d = 1'b1;
        if (count_q != wrmsn_pkg::COUNT_MAX) begin
          count_d = count_q + 1'b1;
        end
        if (last_q) begin
          state_d = S_FIN;
        end else begin
          pos_d   = (pos_q == wrmsn_pkg::POS_LAST) ? '0 : pos_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FIN: begin
        if (seen_q) begin
          rem_d   = '0;
          dq_d    = sum_q;
          scl_d   = {{(W-wrmsn_pkg::COUNT_W){1'b0}}, count_q};
          cnt_d   = 6'd63;
          state_d = S_MDIV;
        end else begin
          root_d  = '0;
          state_d = S_DONE;
        end
      end
      S_ROOT_INIT: begin
        rem_d   = dq_q;
        root_d  = '0;
        cnt_d   = 6'd31;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        // One digit of the bitwise integer square root.
        if (cs_ge) begin
          rem_d  = cs_diff;
          root_d = (root_q >> 1) | sqrt_bit;
        end else begin
          root_d = root_q >> 1;
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Load the result once the output register is free, then clear the vector.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          norm_d      = root_q[VW-1:0];
          oratio_d    = best_q;
          oidx_d      = best_pos_q;
          oany_d      = seen_q;
          sum_d       = '0;
          count_d     = '0;
          pos_d       = '0;
          best_d      = '0;
          best_pos_d  = '0;
          seen_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      abs_tol_q   <= wrmsn_pkg::TOL_RESET;
      rel_tol_q   <= wrmsn_pkg::TOL_RESET;
      sum_q       <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      best_q      <= '0;
      best_pos_q  <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      abs_tol_q   <= abs_tol_d;
      rel_tol_q   <= rel_tol_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      best_q      <= best_d;
      best_pos_q  <= best_pos_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    coarse_q  <= coarse_d;
    refined_q <= refined_d;
    prior_q   <= prior_d;
    scale_q   <= scale_d;
    last_q    <= last_d;
    mmax_q    <= mmax_d;
    dif_q     <= dif_d;
    prod_q    <= prod_d;
    scl_q     <= scl_d;
    rem_q     <= rem_d;
    dq_q      <= dq_d;
    root_q    <= root_d;
    norm_q    <= norm_d;
    oratio_q  <= oratio_d;
    oidx_q    <= oidx_d;
    oany_q    <= oany_d;
  end

  // The partial remainder stays below the divisor during both divisions.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV || state_q == S_MDIV) |-> (rem_q < scl_q))
    else $error("division remainder not below divisor");

  // With no controlled element seen, the accumulators hold their cleared values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (count_q == '0 && best_q == '0 && best_pos_q == '0 && sum_q == '0))
    else $error("accumulators not clear without a controlled element");

  // A result word appears only after the sequencer finished a vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result word without a finished vector");

endmodule
